FILE: rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

   localparam int DefMaxLen = 64;
   localparam logic [15:0] DefTimeoutLimit = 16'd1000;

   // command codes
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_LOAD   = 3'd1;
   localparam logic [2:0] CMD_READ   = 3'd2;
   localparam logic [2:0] CMD_WRITE  = 3'd3;
   localparam logic [2:0] CMD_STATUS = 3'd4;

   // bus status codes
   localparam logic [2:0] ST_START_SENT   = 3'd0;
   localparam logic [2:0] ST_RESTART_SENT = 3'd1;
   localparam logic [2:0] ST_ADDRW_ACKED  = 3'd2;
   localparam logic [2:0] ST_DATA_ACKED   = 3'd3;
   localparam logic [2:0] ST_ADDRR_ACKED  = 3'd4;
   localparam logic [2:0] ST_RX_ACKED     = 3'd5;
   localparam logic [2:0] ST_RX_NACKED    = 3'd6;

   // bus actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_STOP    = 3'd2;
   localparam logic [2:0] ACT_TX      = 3'd3;
   localparam logic [2:0] ACT_RX_ACK  = 3'd4;
   localparam logic [2:0] ACT_RX_NACK = 3'd5;

   // error codes
   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_TIMEOUT = 2'd1;
   localparam logic [1:0] ERR_BAD_LEN = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_START   = 4'd1,
      PH_ADDRW   = 4'd2,
      PH_REG     = 4'd3,
      PH_RESTART = 4'd4,
      PH_ADDRR   = 4'd5,
      PH_RX      = 4'd6,
      PH_WDATA   = 4'd7
   } phase_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [6:0] length;
      logic [7:0] wr_byte;
      logic [2:0] bus_status;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_action;
      logic [7:0] tx_byte;
      logic       rd_valid;
      logic [7:0] rd_byte;
      logic [5:0] rd_index;
      logic       done_res;
      logic [1:0] error_code;
      logic       busy_res;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/i2cm_wbuf.sv
`default_nettype none

module i2cm_wbuf #(
   parameter int MAX_LEN = i2cm_pkg::DefMaxLen
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
   input  wire logic [7:0]             wr_data,
   input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr,
   output logic      [7:0]             rd_data
);
   import i2cm_pkg::*;

   logic [7:0] mem [MAX_LEN];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/i2cm_seq.sv
`default_nettype none

module i2cm_seq #(
   parameter int MAX_LEN = i2cm_pkg::DefMaxLen
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire i2cm_pkg::req_type item,
   input  wire logic [15:0]       timeout_limit,
   output i2cm_pkg::rsp_type      result
);
   import i2cm_pkg::*;

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PW = $clog2(MAX_LEN + 1);

   phase_type     phase_ff, phase_in;
   logic          is_read_ff, is_read_in;
   logic [6:0]    target_addr_ff, target_addr_in;
   logic [7:0]    target_reg_ff, target_reg_in;
   logic [6:0]    xfer_len_ff, xfer_len_in;
   logic [6:0]    byte_count_ff, byte_count_in;
   logic [15:0]   wait_ticks_ff, wait_ticks_in;
   logic [PW-1:0] fill_ptr_ff, fill_ptr_in;

   logic          buf_we;
   logic [AW-1:0] buf_waddr;
   logic [AW-1:0] buf_raddr;
   logic [7:0]    buf_rdata;
   logic [AW+6:0] fill_wide;
   logic [AW+6:0] count_wide;
   logic [15:0]   ticks_inc;
   logic [6:0]    count_inc;
   logic [7:0]    count_inc2;
   logic          len_too_big;
   logic [2:0]    want_status;

   // buffer read address follows the next byte count, so the registered entry matches the current byte count
   assign fill_wide  = (AW + 7)'(fill_ptr_ff);
   assign count_wide = (AW + 7)'(byte_count_in);
   assign buf_waddr  = fill_wide[AW-1:0];
   assign buf_raddr  = count_wide[AW-1:0];

   i2cm_wbuf #(.MAX_LEN(MAX_LEN)) u_wbuf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (item.wr_byte),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   assign ticks_inc   = wait_ticks_ff + 16'd1;
   assign count_inc   = byte_count_ff + 7'd1;
   assign count_inc2  = {1'b0, count_inc} + 8'd1;
   assign len_too_big = 32'(item.length) > 32'(MAX_LEN);
   assign want_status = ({1'b0, count_inc} < {1'b0, xfer_len_ff}) ? ST_RX_ACKED : ST_RX_NACKED;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         is_read_ff     <= 1'b0;
         target_addr_ff <= '0;
         target_reg_ff  <= '0;
         xfer_len_ff    <= '0;
         byte_count_ff  <= '0;
         wait_ticks_ff  <= '0;
         fill_ptr_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         is_read_ff     <= is_read_in;
         target_addr_ff <= target_addr_in;
         target_reg_ff  <= target_reg_in;
         xfer_len_ff    <= xfer_len_in;
         byte_count_ff  <= byte_count_in;
         wait_ticks_ff  <= wait_ticks_in;
         fill_ptr_ff    <= fill_ptr_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      is_read_in     = is_read_ff;
      target_addr_in = target_addr_ff;
      target_reg_in  = target_reg_ff;
      xfer_len_in    = xfer_len_ff;
      byte_count_in  = byte_count_ff;
      wait_ticks_in  = wait_ticks_ff;
      fill_ptr_in    = fill_ptr_ff;
      buf_we         = 1'b0;
      result         = '0;

      if (item_valid) begin
         unique case (item.cmd)
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  wait_ticks_in = ticks_inc;
                  if (ticks_inc >= timeout_limit) begin
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.error_code = ERR_TIMEOUT;
                     phase_in          = PH_IDLE;
                     wait_ticks_in     = '0;
                  end
               end
            end
            CMD_LOAD: begin
               if (phase_ff == PH_IDLE && 32'(fill_ptr_ff) < 32'(MAX_LEN)) begin
                  buf_we      = 1'b1;
                  fill_ptr_in = fill_ptr_ff + PW'(1);
               end
            end
            CMD_READ, CMD_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  if (item.cmd == CMD_WRITE) begin
                     fill_ptr_in = '0;
                  end
                  if (len_too_big || (item.cmd == CMD_READ && item.length == 7'd0)) begin
                     result.done_res   = 1'b1;
                     result.error_code = ERR_BAD_LEN;
                     wait_ticks_in     = '0;
                  end else begin
                     is_read_in        = (item.cmd == CMD_READ);
                     target_addr_in    = item.dev_addr;
                     target_reg_in     = item.reg_addr;
                     xfer_len_in       = item.length;
                     byte_count_in     = '0;
                     result.bus_action = ACT_START;
                     phase_in          = PH_START;
                     wait_ticks_in     = '0;
                  end
               end
            end
            CMD_STATUS: begin
               unique case (phase_ff)
                  PH_START: begin
                     if (item.bus_status == ST_START_SENT) begin
                        result.bus_action = ACT_TX;
                        result.tx_byte    = {target_addr_ff, 1'b0};
                        phase_in          = PH_ADDRW;
                        wait_ticks_in     = '0;
                     end
                  end
                  PH_ADDRW: begin
                     if (item.bus_status == ST_ADDRW_ACKED) begin
                        result.bus_action = ACT_TX;
                        result.tx_byte    = target_reg_ff;
                        phase_in          = PH_REG;
                        wait_ticks_in     = '0;
                     end
                  end
                  PH_REG: begin
                     if (item.bus_status == ST_DATA_ACKED) begin
                        wait_ticks_in = '0;
                        if (is_read_ff) begin
                           result.bus_action = ACT_START;
                           phase_in          = PH_RESTART;
                        end else if (xfer_len_ff == 7'd0) begin
                           result.bus_action = ACT_STOP;
                           result.done_res   = 1'b1;
                           phase_in          = PH_IDLE;
                        end else begin
                           result.bus_action = ACT_TX;
                           result.tx_byte    = buf_rdata;
                           phase_in          = PH_WDATA;
                           byte_count_in     = 7'd1;
                        end
                     end
                  end
                  PH_RESTART: begin
                     if (item.bus_status == ST_RESTART_SENT) begin
                        result.bus_action = ACT_TX;
                        result.tx_byte    = {target_addr_ff, 1'b1};
                        phase_in          = PH_ADDRR;
                        wait_ticks_in     = '0;
                     end
                  end
                  PH_ADDRR: begin
                     if (item.bus_status == ST_ADDRR_ACKED) begin
                        result.bus_action = ({1'b0, count_inc} < {1'b0, xfer_len_ff}) ?
                                            ACT_RX_ACK : ACT_RX_NACK;
                        phase_in          = PH_RX;
                        wait_ticks_in     = '0;
                     end
                  end
                  PH_RX: begin
                     if (item.bus_status == want_status) begin
                        result.rd_valid = 1'b1;
                        result.rd_byte  = item.rx_byte;
                        result.rd_index = byte_count_ff[5:0];
                        byte_count_in   = count_inc;
                        wait_ticks_in   = '0;
                        if (count_inc < xfer_len_ff) begin
                           // ack all but the last byte
                           result.bus_action = (count_inc2 < {1'b0, xfer_len_ff}) ?
                                               ACT_RX_ACK : ACT_RX_NACK;
                        end else begin
                           result.bus_action = ACT_STOP;
                           result.done_res   = 1'b1;
                           phase_in          = PH_IDLE;
                        end
                     end
                  end
                  PH_WDATA: begin
                     if (item.bus_status == ST_DATA_ACKED) begin
                        wait_ticks_in = '0;
                        if (byte_count_ff < xfer_len_ff) begin
                           result.bus_action = ACT_TX;
                           result.tx_byte    = buf_rdata;
                           byte_count_in     = count_inc;
                        end else begin
                           result.bus_action = ACT_STOP;
                           result.done_res   = 1'b1;
                           phase_in          = PH_IDLE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      result.busy_res = (phase_in != PH_IDLE);
   end

endmodule

`default_nettype wire

FILE: rtl/i2c_master_register_transaction.sv
// channel   direction  ports                          accepted when
// req       in         req_valid/req_ready, req_*     req_valid && req_ready
// rsp       out        rsp_valid/rsp_ready, rsp_*     rsp_valid && rsp_ready
// csr       in         csr_valid/csr_ready, csr_*     csr_valid && csr_ready
//
// one transaction per cycle sustained while rsp_ready is high; each request gives exactly one response
// a request passes through the request register, then sequencer logic into the response register
// the write buffer read is registered and its address tracks the next byte count, ahead of use
// synchronous active-high reset clears control state; the write buffer is not cleared
// a stalled response holds the sequencer while the request register keeps accepting once
`default_nettype none

module i2c_master_register_transaction #(
   parameter int MAX_LEN = i2cm_pkg::DefMaxLen
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [6:0]  req_dev_addr,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [6:0]  req_length,
   input  wire logic [7:0]  req_wr_byte,
   input  wire logic [2:0]  req_bus_status,
   input  wire logic [7:0]  req_rx_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_bus_action,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_rd_valid,
   output logic [7:0]       rsp_rd_byte,
   output logic [5:0]       rsp_rd_index,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_busy_res,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_timeout_limit
);
   import i2cm_pkg::*;

   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     seq_result;
   logic [15:0] timeout_limit_ff;
   logic        advance;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign csr_ready   = 1'b1;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         timeout_limit_ff <= DefTimeoutLimit;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_limit_ff <= csr_timeout_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.cmd        <= req_cmd;
         in_ff.dev_addr   <= req_dev_addr;
         in_ff.reg_addr   <= req_reg_addr;
         in_ff.length     <= req_length;
         in_ff.wr_byte    <= req_wr_byte;
         in_ff.bus_status <= req_bus_status;
         in_ff.rx_byte    <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= seq_result;
      end
   end

   i2cm_seq #(.MAX_LEN(MAX_LEN)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (advance),
      .item          (in_ff),
      .timeout_limit (timeout_limit_ff),
      .result        (seq_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bus_action = rsp_ff.bus_action;
   assign rsp_tx_byte    = rsp_ff.tx_byte;
   assign rsp_rd_valid   = rsp_ff.rd_valid;
   assign rsp_rd_byte    = rsp_ff.rd_byte;
   assign rsp_rd_index   = rsp_ff.rd_index;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_error_code = rsp_ff.error_code;
   assign rsp_busy_res   = rsp_ff.busy_res;

`ifndef NO_ASSERTIONS
   a_fill_output: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending transaction not moved into response register");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_res) |-> !rsp_busy_res)
      else $error("busy still set on finished transaction");

   a_error_with_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_code != ERR_OK) |-> rsp_done_res)
      else $error("error code without done");

   a_rd_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rd_valid) |->
      (rsp_bus_action == ACT_RX_ACK || rsp_bus_action == ACT_RX_NACK ||
       rsp_bus_action == ACT_STOP))
      else $error("received byte without follow-up action");
`endif

endmodule

`default_nettype wire
